>>> sv/rdsp_pkg.sv
`default_nettype none

package rdsp_pkg;

    // Width of the value field on the result port.
    localparam int unsigned VALUE_W = 64;

    // Character codes the parser recognizes.
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_POINT   = 8'h2E;

    // Base limits and letter value offsets.
    localparam logic [5:0] RADIX_MIN       = 6'd2;
    localparam logic [5:0] RADIX_CASELESS  = 6'd36;
    localparam logic [5:0] RADIX_MAX       = 6'd62;
    localparam logic [5:0] LETTER_BASE_LO  = 6'd10;
    localparam logic [5:0] LETTER_BASE_HI  = 6'd36;

    // Configuration register indexes.
    localparam logic [7:0] CFG_RADIX       = 8'd0;
    localparam logic [7:0] CFG_LOWER_FIRST = 8'd1;
    localparam logic [7:0] CFG_MIN_DIGITS  = 8'd2;
    localparam logic [7:0] CFG_MAX_DIGITS  = 8'd3;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_TOO_FEW   = 2'd1,
        STATUS_BAD_RADIX = 2'd2
    } rdsp_status_t;

    // Configuration seen by the parsing core.
    typedef struct packed {
        logic [5:0] radix;
        logic       lower_first;
        logic [7:0] min_digits;
        logic [7:0] max_digits;
    } rdsp_cfg_t;

    // Classified character.
    typedef struct packed {
        logic       is_alnum;
        logic [5:0] digit;
    } rdsp_digit_t;

    // One result item.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [7:0]         digit_count;
        logic               has_point;
        logic [7:0]         fraction_digits;
        logic [7:0]         stop_char;
        logic               ended_by_stream;
        rdsp_status_t       status;
    } rdsp_result_t;

endpackage

`default_nettype wire

>>> sv/radix_digit_string_parser.sv
`default_nettype none

// Radix digit string parser. Characters arrive one item per cycle on the
// slave stream (tdata bits 7:0, tlast flags end of stream) and build a number
// in the base set by configuration register 0, with letter order set by
// register 1 and digit count bounds by registers 2 and 3. Each accepted item
// waits in an input register, where the multiply-add by the base and
// the digit decode run; a finished number is then held in the output register
// until the master side takes it. The block sustains one item per cycle unless
// a finished result waits untaken, and a result passes from the input register
// into the output register, which drives the master side; the clock period is
// set by the accumulator multiply-add. The input stalls only while a finished
// result waits in the output register and the master side does not take it.
// Configuration must be written only while no item is in flight.
module radix_digit_string_parser
#(
    parameter int unsigned VALUE_BITS  = 64,
    parameter int unsigned DIGIT_LIMIT = 255
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write port.
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [7:0]  cfg_wdata,
    // Character input.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // char_code[7:0]
    input  wire logic        s_tlast,   // end_of_stream
    // Result output.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,   // value[63:0], digit_count[71:64],
                                        // has_point[72], fraction_digits[80:73],
                                        // stop_char[88:81], zero pad[95:89]
    output logic             m_tlast,   // ended_by_stream
    output logic [1:0]       m_tuser    // status
);
    import rdsp_pkg::*;

    rdsp_cfg_t     cfg_reg;
    logic          in_valid_reg;
    logic [7:0]    in_char_reg;
    logic          in_eos_reg;
    logic          out_valid_reg;
    rdsp_result_t  out_data_reg;

    logic          emit;
    logic          out_free;
    logic          advance;
    rdsp_result_t  result;

    rdsp_number_core
    #(
        .VALUE_BITS  (VALUE_BITS),
        .DIGIT_LIMIT (DIGIT_LIMIT)
    )
    u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (in_valid_reg),
        .advance       (advance),
        .char_code     (in_char_reg),
        .end_of_stream (in_eos_reg),
        .cfg           (cfg_reg),
        .emit          (emit),
        .result        (result)
    );

    // Pipeline flow: the held item moves on unless its result has nowhere to go.
    always_comb
    begin
        out_free = !out_valid_reg || m_tready;
        advance  = in_valid_reg && (!emit || out_free);
        s_tready = !in_valid_reg || advance;
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.radix       <= 6'd10;
            cfg_reg.lower_first <= 1'b1;
            cfg_reg.min_digits  <= '0;
            cfg_reg.max_digits  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RADIX:       cfg_reg.radix       <= cfg_wdata[5:0];
                CFG_LOWER_FIRST: cfg_reg.lower_first <= cfg_wdata[0];
                CFG_MIN_DIGITS:  cfg_reg.min_digits  <= cfg_wdata;
                CFG_MAX_DIGITS:  cfg_reg.max_digits  <= cfg_wdata;
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // Valid flags of the input and output registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the input and output registers.
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_char_reg <= s_tdata;
            in_eos_reg  <= s_tlast;
        end
        if (advance && emit)
        begin
            out_data_reg <= result;
        end
    end

    // Result port packing.
    always_comb
    begin
        m_tvalid = out_valid_reg;
        m_tdata  = {7'd0,
                    out_data_reg.stop_char,
                    out_data_reg.fraction_digits,
                    out_data_reg.has_point,
                    out_data_reg.digit_count,
                    out_data_reg.value};
        m_tlast  = out_data_reg.ended_by_stream;
        m_tuser  = out_data_reg.status;
    end

endmodule

`default_nettype wire

>>> sv/rdsp_digit_decode.sv
`default_nettype none

module rdsp_digit_decode
(
    input  wire logic [7:0]          char_code,
    input  wire logic [5:0]          radix,
    input  wire logic                lower_first,
    output rdsp_pkg::rdsp_digit_t    digit
);
    import rdsp_pkg::*;

    logic [5:0] up_base;
    logic [5:0] low_base;

    // Letter offsets depend on whether case matters in this base.
    always_comb
    begin
        if (radix <= RADIX_CASELESS)
        begin
            up_base  = LETTER_BASE_LO;
            low_base = LETTER_BASE_LO;
        end
        else if (lower_first)
        begin
            up_base  = LETTER_BASE_HI;
            low_base = LETTER_BASE_LO;
        end
        else
        begin
            up_base  = LETTER_BASE_LO;
            low_base = LETTER_BASE_HI;
        end
    end

    // Map the character to its digit value.
    always_comb
    begin
        digit.is_alnum = 1'b1;
        digit.digit    = '0;
        if (char_code >= CHAR_ZERO && char_code <= CHAR_NINE)
        begin
            digit.digit = 6'(char_code - CHAR_ZERO);
        end
        else if (char_code >= CHAR_UPPER_A && char_code <= CHAR_UPPER_Z)
        begin
            digit.digit = 6'(char_code - CHAR_UPPER_A) + up_base;
        end
        else if (char_code >= CHAR_LOWER_A && char_code <= CHAR_LOWER_Z)
        begin
            digit.digit = 6'(char_code - CHAR_LOWER_A) + low_base;
        end
        else
        begin
            digit.is_alnum = 1'b0;
        end
    end

endmodule

`default_nettype wire

>>> sv/rdsp_number_core.sv
`default_nettype none

module rdsp_number_core
#(
    parameter int unsigned VALUE_BITS  = 64,
    parameter int unsigned DIGIT_LIMIT = 255
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    input  wire logic                 advance,
    input  wire logic [7:0]           char_code,
    input  wire logic                 end_of_stream,
    input  wire rdsp_pkg::rdsp_cfg_t  cfg,
    output logic                      emit,
    output rdsp_pkg::rdsp_result_t    result
);
    import rdsp_pkg::*;

    localparam int unsigned CNT_W = $clog2(DIGIT_LIMIT + 1);
    localparam int unsigned CMP_W = (CNT_W > 8) ? CNT_W : 8;
    localparam int unsigned PROD_W = VALUE_BITS + 6;

    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]      digits_reg, digits_next;
    logic [CNT_W-1:0]      frac_reg, frac_next;
    logic                  in_frac_reg, in_frac_next;

    rdsp_digit_t           digit;
    logic                  bad_radix;
    logic [CMP_W-1:0]      limit;
    logic [CMP_W-1:0]      digits_wide;
    logic [CMP_W-1:0]      frac_wide;
    logic                  digit_ok;
    logic [PROD_W-1:0]     product;

    rdsp_digit_decode u_decode
    (
        .char_code   (char_code),
        .radix       (cfg.radix),
        .lower_first (cfg.lower_first),
        .digit       (digit)
    );

    // Base check and effective digit limit.
    always_comb
    begin
        bad_radix = (cfg.radix < RADIX_MIN) || (cfg.radix > RADIX_MAX);
        if (cfg.max_digits == '0 || CMP_W'(cfg.max_digits) > CMP_W'(DIGIT_LIMIT))
        begin
            limit = CMP_W'(DIGIT_LIMIT);
        end
        else
        begin
            limit = CMP_W'(cfg.max_digits);
        end
        digits_wide = CMP_W'(digits_reg);
        frac_wide   = CMP_W'(frac_reg);
        digit_ok    = digit.is_alnum && (digit.digit < cfg.radix);
        product     = PROD_W'(acc_reg) * PROD_W'(cfg.radix);
    end

    // Decide what this item does and form the next state.
    always_comb
    begin
        emit         = 1'b0;
        acc_next     = acc_reg;
        digits_next  = digits_reg;
        frac_next    = frac_reg;
        in_frac_next = in_frac_reg;
        if (item_valid)
        begin
            if (end_of_stream || bad_radix)
            begin
                emit = 1'b1;
            end
            else if (digit_ok)
            begin
                if (digits_wide >= limit)
                begin
                    emit = 1'b1;
                end
                else
                begin
                    acc_next    = product[VALUE_BITS-1:0] + VALUE_BITS'(digit.digit);
                    digits_next = digits_reg + CNT_W'(1);
                    if (in_frac_reg)
                    begin
                        frac_next = frac_reg + CNT_W'(1);
                    end
                end
            end
            else if (char_code == CHAR_POINT && !in_frac_reg)
            begin
                in_frac_next = 1'b1;
            end
            else
            begin
                emit = 1'b1;
            end
        end
        if (emit)
        begin
            acc_next     = '0;
            digits_next  = '0;
            frac_next    = '0;
            in_frac_next = 1'b0;
        end
    end

    // Result fields, built from the state before this item.
    always_comb
    begin
        result.stop_char       = end_of_stream ? 8'h00 : char_code;
        result.ended_by_stream = end_of_stream;
        if (bad_radix)
        begin
            result.value           = '0;
            result.digit_count     = '0;
            result.has_point       = 1'b0;
            result.fraction_digits = '0;
            result.status          = STATUS_BAD_RADIX;
        end
        else
        begin
            result.value           = VALUE_W'(acc_reg);
            result.digit_count     = (digits_wide > CMP_W'(255)) ? 8'hFF : digits_wide[7:0];
            result.has_point       = in_frac_reg;
            result.fraction_digits = (frac_wide > CMP_W'(255)) ? 8'hFF : frac_wide[7:0];
            result.status          = (digits_wide < CMP_W'(cfg.min_digits)) ?
                                     STATUS_TOO_FEW : STATUS_OK;
        end
    end

    // Number state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            digits_reg  <= '0;
            frac_reg    <= '0;
            in_frac_reg <= 1'b0;
        end
        else if (advance)
        begin
            acc_reg     <= acc_next;
            digits_reg  <= digits_next;
            frac_reg    <= frac_next;
            in_frac_reg <= in_frac_next;
        end
    end

endmodule

`default_nettype wire

>>> tb/radix_digit_string_parser_tb.sv
`default_nettype none

module radix_digit_string_parser_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rdsp_pkg::*;

    localparam int unsigned DIGIT_LIMIT   = 255;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned HOLD_CYCLES   = 200;
    localparam int unsigned MAX_REPORTS   = 10;
    localparam int unsigned DRAIN_LIMIT   = 100000;
    localparam logic [7:0]  CHAR_SPACE    = 8'h20;
    localparam logic [7:0]  CHAR_BANG     = 8'h21;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [7:0]  cfg_index = 8'd0;
    logic [7:0]  cfg_wdata = 8'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [95:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    // Shadow copy of the configuration registers.
    logic [5:0]  cfg_radix       = 6'd10;
    logic        cfg_lower_first = 1'b1;
    logic [7:0]  cfg_min         = 8'd0;
    logic [7:0]  cfg_max         = 8'd0;

    // Number being built by the predictor.
    logic [63:0] num_value       = 64'd0;
    int unsigned num_digits      = 0;
    int unsigned num_fraction    = 0;
    logic        num_in_fraction = 1'b0;

    rdsp_result_t pending_results[$];
    int unsigned  error_count  = 0;
    bit           src_idle_on  = 1'b1;
    bit           sink_idle_on = 1'b1;
    logic         sink_hold    = 1'b0;
    event         hold_request;

    radix_digit_string_parser dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // Free-running clock, 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Digit value of a character under the current letter order, 255 if not alphanumeric.
    function automatic int unsigned digit_of(logic [7:0] ch);
        int unsigned upper_base;
        int unsigned lower_base;
        upper_base = LETTER_BASE_LO;
        lower_base = LETTER_BASE_LO;
        if (cfg_radix > RADIX_CASELESS)
        begin
            if (cfg_lower_first)
                upper_base = LETTER_BASE_HI;
            else
                lower_base = LETTER_BASE_HI;
        end
        if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
            return ch - CHAR_ZERO;
        if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z)
            return ch - CHAR_UPPER_A + upper_base;
        if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z)
            return ch - CHAR_LOWER_A + lower_base;
        return 255;
    endfunction

    // Finish the current number: queue its expected result and clear the state.
    function automatic void close_number(logic [7:0] stop, logic by_stream);
        rdsp_result_t r;
        logic         bad;
        bad = (cfg_radix < RADIX_MIN) || (cfg_radix > RADIX_MAX);
        r = '0;
        if (!bad)
        begin
            r.value           = num_value;
            r.digit_count     = (num_digits > 255) ? 8'd255 : num_digits[7:0];
            r.has_point       = num_in_fraction;
            r.fraction_digits = (num_fraction > 255) ? 8'd255 : num_fraction[7:0];
        end
        r.stop_char       = stop;
        r.ended_by_stream = by_stream;
        if (bad)
            r.status = STATUS_BAD_RADIX;
        else if (num_digits < cfg_min)
            r.status = STATUS_TOO_FEW;
        else
            r.status = STATUS_OK;
        pending_results.push_back(r);
        num_value       = 64'd0;
        num_digits      = 0;
        num_fraction    = 0;
        num_in_fraction = 1'b0;
    endfunction

    // Advance the predicted parser by one accepted item.
    function automatic void parse_char(logic [7:0] ch, logic eos);
        int unsigned limit;
        int unsigned d;
        if (eos)
        begin
            close_number(8'd0, 1'b1);
            return;
        end
        if (cfg_radix < RADIX_MIN || cfg_radix > RADIX_MAX)
        begin
            close_number(ch, 1'b0);
            return;
        end
        limit = (cfg_max == 8'd0) ? DIGIT_LIMIT : cfg_max;
        d = digit_of(ch);
        if (d < cfg_radix)
        begin
            // A valid digit past the limit ends the number instead of being taken.
            if (num_digits >= limit)
            begin
                close_number(ch, 1'b0);
                return;
            end
            num_value = num_value * 64'(cfg_radix) + 64'(d);
            num_digits++;
            if (num_in_fraction)
                num_fraction++;
            return;
        end
        if (ch == CHAR_POINT && !num_in_fraction)
        begin
            num_in_fraction = 1'b1;
            return;
        end
        close_number(ch, 1'b0);
    endfunction

    // Character that encodes digit value v under the current letter order.
    function automatic logic [7:0] char_for_digit(int unsigned v);
        if (v < 10)
            return 8'(CHAR_ZERO + v);
        if (cfg_radix <= RADIX_CASELESS && v < 36)
            return $urandom_range(0, 1) ? 8'(CHAR_UPPER_A + v - 10) : 8'(CHAR_LOWER_A + v - 10);
        if (v < 36)
            return cfg_lower_first ? 8'(CHAR_LOWER_A + v - 10) : 8'(CHAR_UPPER_A + v - 10);
        return cfg_lower_first ? 8'(CHAR_UPPER_A + v - 36) : 8'(CHAR_LOWER_A + v - 36);
    endfunction

    // Random byte that is neither a decimal digit nor a letter.
    function automatic logic [7:0] random_symbol();
        logic [7:0] c;
        c = 8'($urandom);
        while (digit_of(c) != 255)
            c = 8'($urandom);
        return c;
    endfunction

    function automatic void report_error(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR at %0t ns: %s", $time, msg);
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
            report_error($sformatf("%s: expected %0h, got %0h", name, want, got));
    endfunction

    // Offer one item, with a random gap before it, and wait for the handshake.
    task automatic send_item(logic [7:0] ch, logic eos);
        while (src_idle_on && $urandom_range(0, 99) < 21)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= eos;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        parse_char(ch, eos);
    endtask

    task automatic send_text(string text);
        int i;
        for (i = 0; i < text.len(); i++)
            send_item(text[i], 1'b0);
    endtask

    // End of stream carries a random character, which the block must ignore.
    task automatic send_end();
        send_item(8'($urandom), 1'b1);
    endtask

    // Register write, done only once every result is out and the pipeline is empty.
    task automatic write_reg(logic [7:0] index, logic [7:0] data);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (index)
            CFG_RADIX:       cfg_radix       = data[5:0];
            CFG_LOWER_FIRST: cfg_lower_first = data[0];
            CFG_MIN_DIGITS:  cfg_min         = data;
            CFG_MAX_DIGITS:  cfg_max         = data;
            default:         ;
        endcase
    endtask

    // One well-formed number with random content and a random way of ending.
    task automatic send_number(ref int unsigned count);
        int unsigned int_len;
        int unsigned frac_len;
        int unsigned top;
        int unsigned i;
        logic        bad;
        bad = (cfg_radix < RADIX_MIN) || (cfg_radix > RADIX_MAX);
        top = bad ? 35 : cfg_radix - 1;
        int_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 6);
        frac_len = $urandom_range(0, 4);
        for (i = 0; i < int_len; i++)
            send_item(char_for_digit($urandom_range(0, top)), 1'b0);
        count += int_len;
        if ($urandom_range(0, 2) == 0)
        begin
            send_item(CHAR_POINT, 1'b0);
            for (i = 0; i < frac_len; i++)
                send_item(char_for_digit($urandom_range(0, top)), 1'b0);
            count += frac_len + 1;
        end
        // Letters above the base only exist below 36 in caseless bases, below 62 otherwise.
        top = (cfg_radix <= RADIX_CASELESS) ? 35 : 61;
        case ($urandom_range(0, 5))
            0: send_end();
            1: send_item(CHAR_POINT, 1'b0);
            2:
            begin
                if (!bad && cfg_radix <= top)
                    send_item(char_for_digit($urandom_range(cfg_radix, top)), 1'b0);
                else
                    send_item(random_symbol(), 1'b0);
            end
            3: send_item(random_symbol(), 1'b0);
            default: send_item(8'($urandom), 1'b0);
        endcase
        count++;
    endtask

    task automatic test_decimal_basics();
        send_text("123.45 ");
        send_text("9");
        send_end();
        send_end();
        send_text("..");
        send_text("A");
        send_text("0.");
        send_item(8'hFF, 1'b1);
        send_item(8'h00, 1'b0);
    endtask

    task automatic test_letter_order();
        write_reg(CFG_RADIX, 8'd62);
        write_reg(CFG_LOWER_FIRST, 8'd1);
        send_text("zZ9");
        send_end();
        write_reg(CFG_LOWER_FIRST, 8'd0);
        send_text("zZ9");
        send_end();
        // Case is folded at 36 and below.
        write_reg(CFG_RADIX, 8'd36);
        send_text("zZ!");
        write_reg(CFG_RADIX, 8'd37);
        send_text("ab");
        write_reg(CFG_LOWER_FIRST, 8'd1);
    endtask

    task automatic test_radix_extremes();
        write_reg(CFG_RADIX, 8'd2);
        send_text("10112");
        write_reg(CFG_RADIX, 8'd0);
        send_text("5");
        send_end();
        // Writes to indexes past the last register change nothing.
        write_reg(8'd4, 8'd10);
        write_reg(8'd255, 8'd10);
        send_text("1");
        write_reg(CFG_RADIX, 8'd1);
        send_text("0");
        write_reg(CFG_RADIX, 8'd63);
        send_text(".");
        // Bits above the six radix bits are dropped.
        write_reg(CFG_RADIX, 8'hCA);
        send_text("42");
        send_end();
        // Base 62 value wraps past 64 bits.
        write_reg(CFG_RADIX, 8'd62);
        send_text("zzzzzzzzzzzz");
        send_end();
    endtask

    task automatic test_digit_limits();
        int i;
        write_reg(CFG_RADIX, 8'd10);
        write_reg(CFG_MAX_DIGITS, 8'd1);
        send_text("12");
        // The point is still taken once the limit is reached.
        write_reg(CFG_MAX_DIGITS, 8'd2);
        send_text("12.3");
        write_reg(CFG_MAX_DIGITS, 8'd0);
        write_reg(CFG_MIN_DIGITS, 8'd3);
        send_text("12");
        send_end();
        // Full-length number: the default limit stops it at 255 digits.
        write_reg(CFG_MIN_DIGITS, 8'd255);
        for (i = 0; i < 256; i++)
            send_item(8'(CHAR_ZERO + $urandom_range(0, 9)), 1'b0);
        send_text("1");
        send_end();
        write_reg(CFG_MAX_DIGITS, 8'd255);
        write_reg(CFG_MIN_DIGITS, 8'd0);
        send_text("999");
        send_end();
        write_reg(CFG_MAX_DIGITS, 8'd0);
    endtask

    task automatic test_random_numbers();
        int unsigned phase;
        int unsigned sent;
        logic [5:0]  radix_pick;
        for (phase = 0; phase < 8; phase++)
        begin
            case ($urandom_range(0, 9))
                0:       radix_pick = ($urandom_range(0, 1) != 0) ? 6'd63 : 6'($urandom_range(0, 1));
                1:       radix_pick = RADIX_MIN;
                2:       radix_pick = RADIX_MAX;
                3:       radix_pick = RADIX_CASELESS;
                4:       radix_pick = 6'd37;
                default: radix_pick = 6'($urandom_range(2, 62));
            endcase
            write_reg(CFG_RADIX, {2'($urandom), radix_pick});
            write_reg(CFG_LOWER_FIRST, 8'($urandom));
            case ($urandom_range(0, 5))
                0:       write_reg(CFG_MIN_DIGITS, 8'($urandom_range(1, 6)));
                1:       write_reg(CFG_MIN_DIGITS, 8'd255);
                default: write_reg(CFG_MIN_DIGITS, 8'd0);
            endcase
            case ($urandom_range(0, 5))
                0:       write_reg(CFG_MAX_DIGITS, 8'($urandom_range(1, 8)));
                1:       write_reg(CFG_MAX_DIGITS, 8'($urandom_range(9, 255)));
                default: write_reg(CFG_MAX_DIGITS, 8'd0);
            endcase
            if ($urandom_range(0, 3) == 0)
                write_reg(8'($urandom_range(4, 255)), 8'($urandom));
            sent = 0;
            while (sent < 35)
            begin
                if ($urandom_range(0, 9) < 8)
                    send_number(sent);
                else
                begin
                    send_item(8'($urandom), ($urandom_range(0, 9) == 0));
                    sent++;
                end
            end
            send_end();
        end
    endtask

    // Back-to-back items with both sides always ready.
    task automatic test_full_rate();
        int unsigned sent;
        write_reg(CFG_RADIX, 8'd16);
        write_reg(CFG_MIN_DIGITS, 8'd0);
        write_reg(CFG_MAX_DIGITS, 8'd0);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        sent = 0;
        while (sent < 150)
            send_number(sent);
        send_end();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    // Receiver holds off while results pile up and the input stalls.
    task automatic test_backpressure();
        int i;
        write_reg(CFG_RADIX, 8'd10);
        src_idle_on = 1'b0;
        -> hold_request;
        for (i = 0; i < 30; i++)
        begin
            send_item(8'(CHAR_ZERO + $urandom_range(0, 9)), 1'b0);
            send_item(CHAR_SPACE + 8'(i % 2), 1'b0);
        end
        send_item(CHAR_BANG, 1'b0);
        src_idle_on = 1'b1;
    endtask

    // Receiver ready: random stalls, a counted hold-off on request.
    always @(posedge clk)
    begin
        if (sink_hold)
            m_tready <= 1'b0;
        else if (sink_idle_on)
            m_tready <= ($urandom_range(0, 99) >= 21);
        else
            m_tready <= 1'b1;
    end

    initial
    begin
        forever
        begin
            @(hold_request);
            sink_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            sink_hold <= 1'b0;
        end
    end

    // Compare each accepted result with the oldest expected one.
    always @(posedge clk)
    begin : result_check
        rdsp_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_error($sformatf("unexpected result: tdata=%h tlast=%b tuser=%0d",
                                       m_tdata, m_tlast, m_tuser));
            else
            begin
                want = pending_results.pop_front();
                check_field("value", want.value, m_tdata[63:0]);
                check_field("digit_count", 64'(want.digit_count), 64'(m_tdata[71:64]));
                check_field("has_point", 64'(want.has_point), 64'(m_tdata[72]));
                check_field("fraction_digits", 64'(want.fraction_digits), 64'(m_tdata[80:73]));
                check_field("stop_char", 64'(want.stop_char), 64'(m_tdata[88:81]));
                check_field("ended_by_stream", 64'(want.ended_by_stream), 64'(m_tlast));
                check_field("status", 64'(want.status), 64'(m_tuser));
            end
        end
    end

    initial
    begin : main_sequence
        int unsigned drain_wait;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_decimal_basics();
        test_letter_order();
        test_radix_extremes();
        test_digit_limits();
        test_random_numbers();
        test_full_rate();
        test_backpressure();
        s_tvalid <= 1'b0;
        drain_wait = 0;
        while (pending_results.size() != 0 && drain_wait < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (8) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
        begin
            if (pending_results.size() != 0)
                $display("ERROR: %0d expected results never arrived", pending_results.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2000000;
        $display("ERROR: timeout");
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
sv/rdsp_pkg.sv
sv/rdsp_digit_decode.sv
sv/rdsp_number_core.sv
sv/radix_digit_string_parser.sv
tb/radix_digit_string_parser_tb.sv
